// ----- hw/rtl/pdx_pkg.sv -----
// ----------------------------------------------------------------------------
// pdx_pkg
// Shared constants and controller/datapath interface types for the packet
// deframer with xor checksum.
// ----------------------------------------------------------------------------
package pdx_pkg;

  localparam int MAX_PAYLOAD_DEFAULT = 64;

  localparam int LIMIT_W = 7;
  localparam int BYTE_W  = 8;
  localparam int INDEX_W = 6;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 7'd64;

  localparam logic [BYTE_W-1:0] START_A = 8'h06;
  localparam logic [BYTE_W-1:0] START_B = 8'h85;

  // controller -> datapath
  typedef struct packed {
    logic load_len;       // length byte accepted
    logic push_data;      // payload byte accepted
    logic start_deliver;  // checksum matched, latch limit and clear position
    logic read_entry;     // fetch buffer entry at the delivery position
    logic next_entry;     // advance delivery position
  } pdx_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic is_start_a;
    logic is_start_b;
    logic len_ok;
    logic len_zero;
    logic data_done;
    logic check_ok;
    logic lim_zero;
    logic deliver_last;
  } pdx_status_t;

endpackage

// ----- hw/rtl/pdx_datapath.sv -----
// ----------------------------------------------------------------------------
// pdx_datapath
// Limit register, length/position/checksum registers, payload buffer and the
// delivery position counter with its output registers.
// ----------------------------------------------------------------------------
module pdx_datapath #(
  parameter int MAX_PAYLOAD = pdx_pkg::MAX_PAYLOAD_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [pdx_pkg::LIMIT_W-1:0]   cfg_data,
  input  logic [pdx_pkg::BYTE_W-1:0]    rx_byte,
  input  pdx_pkg::pdx_cmd_t             cmd,
  output pdx_pkg::pdx_status_t          status,
  output logic [pdx_pkg::BYTE_W-1:0]    out_byte,
  output logic [pdx_pkg::INDEX_W-1:0]   out_index,
  output logic                          out_last
);

  localparam int ADDR_W = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
  localparam logic [pdx_pkg::BYTE_W-1:0] MaxB = pdx_pkg::BYTE_W'(MAX_PAYLOAD);

  logic [pdx_pkg::LIMIT_W-1:0] payload_limit;
  logic [pdx_pkg::LIMIT_W-1:0] packet_length;
  logic [pdx_pkg::LIMIT_W-1:0] fill_position;
  logic [pdx_pkg::BYTE_W-1:0]  running_check;
  logic [pdx_pkg::LIMIT_W-1:0] deliver_lim;
  logic [pdx_pkg::LIMIT_W-1:0] deliver_pos;
  logic [pdx_pkg::BYTE_W-1:0]  rd_data;
  logic                        rd_use;

  logic [pdx_pkg::BYTE_W-1:0]  payload_store [MAX_PAYLOAD];

  logic [pdx_pkg::LIMIT_W-1:0] eff_lim;
  logic [pdx_pkg::BYTE_W-1:0]  fill_inc;
  logic [pdx_pkg::BYTE_W-1:0]  pos_inc;
  logic                        fill_in_range;
  logic                        pos_in_range;

  // limit saturated to the buffer depth
  assign eff_lim = (pdx_pkg::BYTE_W'(payload_limit) > MaxB) ?
                   pdx_pkg::LIMIT_W'(MaxB) : payload_limit;

  assign fill_inc      = pdx_pkg::BYTE_W'(fill_position) + 8'd1;
  assign pos_inc       = pdx_pkg::BYTE_W'(deliver_pos) + 8'd1;
  assign fill_in_range = pdx_pkg::BYTE_W'(fill_position) < MaxB;
  assign pos_in_range  = (deliver_pos < packet_length) &&
                         (pdx_pkg::BYTE_W'(deliver_pos) < MaxB);

  always_comb begin
    status.is_start_a   = rx_byte == pdx_pkg::START_A;
    status.is_start_b   = rx_byte == pdx_pkg::START_B;
    status.len_ok       = rx_byte <= pdx_pkg::BYTE_W'(eff_lim);
    status.len_zero     = rx_byte == '0;
    status.data_done    = fill_inc >= pdx_pkg::BYTE_W'(packet_length);
    status.check_ok     = running_check == rx_byte;
    status.lim_zero     = eff_lim == '0;
    status.deliver_last = pos_inc == pdx_pkg::BYTE_W'(deliver_lim);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      payload_limit <= pdx_pkg::LIMIT_RESET;
      packet_length <= '0;
      fill_position <= '0;
      running_check <= '0;
      deliver_pos   <= '0;
      deliver_lim   <= '0;
    end else begin
      if (cfg_we) begin
        payload_limit <= cfg_data;
      end
      if (cmd.load_len) begin
        packet_length <= rx_byte[pdx_pkg::LIMIT_W-1:0];
        fill_position <= '0;
        running_check <= rx_byte;
      end
      if (cmd.push_data) begin
        running_check <= running_check ^ rx_byte;
        fill_position <= fill_inc[pdx_pkg::LIMIT_W-1:0];
      end
      if (cmd.start_deliver) begin
        deliver_lim <= eff_lim;
        deliver_pos <= '0;
      end
      if (cmd.next_entry) begin
        deliver_pos <= pos_inc[pdx_pkg::LIMIT_W-1:0];
      end
    end
  end

  // payload buffer, one write and one registered read port
  always_ff @(posedge clk) begin
    if (cmd.push_data && fill_in_range) begin
      payload_store[ADDR_W'(fill_position)] <= rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.read_entry) begin
      rd_data <= payload_store[ADDR_W'(deliver_pos)];
      rd_use  <= pos_in_range;
    end
  end

  // positions past the received length deliver zero
  assign out_byte  = rd_use ? rd_data : '0;
  assign out_index = deliver_pos[pdx_pkg::INDEX_W-1:0];
  assign out_last  = status.deliver_last;

endmodule

// ----- hw/rtl/pdx_ctrl.sv -----
// ----------------------------------------------------------------------------
// pdx_ctrl
// Frame state machine: start pair hunt, length, payload, checksum, and the
// read/present loop that delivers a good packet.
// ----------------------------------------------------------------------------
module pdx_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  output logic                  out_valid,
  input  logic                  out_ready,
  input  pdx_pkg::pdx_status_t  status,
  output pdx_pkg::pdx_cmd_t     cmd
);

  typedef enum logic [2:0] {
    ST_HUNT_A,
    ST_HUNT_B,
    ST_LENGTH,
    ST_DATA,
    ST_CHECK,
    ST_READ,
    ST_SHOW
  } state_t;

  state_t state;
  state_t state_next;
  logic   in_fire;

  assign in_ready  = (state != ST_READ) && (state != ST_SHOW);
  assign out_valid = state == ST_SHOW;
  assign in_fire   = in_valid && in_ready;

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      ST_HUNT_A: begin
        if (in_fire && status.is_start_a) state_next = ST_HUNT_B;
      end
      ST_HUNT_B: begin
        if (in_fire) state_next = status.is_start_b ? ST_LENGTH : ST_HUNT_A;
      end
      ST_LENGTH: begin
        if (in_fire) begin
          if (status.len_ok) begin
            cmd.load_len = 1'b1;
            state_next   = status.len_zero ? ST_CHECK : ST_DATA;
          end else begin
            state_next = ST_HUNT_A;
          end
        end
      end
      ST_DATA: begin
        if (in_fire) begin
          cmd.push_data = 1'b1;
          if (status.data_done) state_next = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (in_fire) begin
          if (status.check_ok && !status.lim_zero) begin
            cmd.start_deliver = 1'b1;
            state_next        = ST_READ;
          end else begin
            state_next = ST_HUNT_A;
          end
        end
      end
      ST_READ: begin
        cmd.read_entry = 1'b1;
        state_next     = ST_SHOW;
      end
      ST_SHOW: begin
        if (out_ready) begin
          if (status.deliver_last) begin
            state_next = ST_HUNT_A;
          end else begin
            cmd.next_entry = 1'b1;
            state_next     = ST_READ;
          end
        end
      end
      default: state_next = ST_HUNT_A;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_HUNT_A;
    end else begin
      state <= state_next;
    end
  end

`ifndef SYNTHESIS
  // no input taken while a byte is on offer
  assert property (@(posedge clk) disable iff (rst) out_valid |-> !in_ready)
    else $error("input accepted during delivery");

  // final byte taken returns to hunting
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && status.deliver_last) |=> (in_ready && !out_valid))
    else $error("delivery did not end after final byte");

  // a bad checksum never starts delivery
  assert property (@(posedge clk) disable iff (rst)
    (in_fire && state == ST_CHECK && !status.check_ok) |=> !cmd.read_entry)
    else $error("delivery started on checksum mismatch");

  // each accepted non-final byte is followed by a buffer read
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && !status.deliver_last) |=> cmd.read_entry)
    else $error("missing read for next byte");
`endif

endmodule

// ----- hw/rtl/packet_deframer_xor_check.sv -----
// delivery: after a good packet's checksum transaction the controller reads
//   the buffer (ST_READ), then offers the first byte (ST_SHOW) until it is
//   taken; each later byte again passes through a buffer read before it is offered
// throughput: one received byte per cycle while framing; delivery takes a
//   buffer read, then a held output, for each byte, limit bytes in total
// reset: control returns to hunting and the limit to 64; buffer is not cleared
// ----------------------------------------------------------------------------
// packet_deframer_xor_check
// Recovers 0x06 0x85 framed packets with an xor checksum and delivers the
// payload, padded with zeros to the configured limit.
// ----------------------------------------------------------------------------
module packet_deframer_xor_check #(
  parameter int MAX_PAYLOAD = pdx_pkg::MAX_PAYLOAD_DEFAULT
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [pdx_pkg::LIMIT_W-1:0]  cfg_data,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [pdx_pkg::BYTE_W-1:0]   rx_byte,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [pdx_pkg::BYTE_W-1:0]   out_byte,
  output logic [pdx_pkg::INDEX_W-1:0]  out_index,
  output logic                         out_last
);

  pdx_pkg::pdx_cmd_t    cmd;
  pdx_pkg::pdx_status_t status;

  assign cfg_ready = 1'b1;

  pdx_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  pdx_datapath #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_data  (cfg_data),
    .rx_byte   (rx_byte),
    .cmd       (cmd),
    .status    (status),
    .out_byte  (out_byte),
    .out_index (out_index),
    .out_last  (out_last)
  );

endmodule
